// ----- rtl/qapm_pkg.sv -----
`timescale 1ns / 1ps

package qapm_pkg;

    // fraction bits of the control sums: Q8.8 gain times Q3.12 signal
    localparam int FRAC = 20;
    // width of the mixer sums, wide enough for every term at FRAC bits
    localparam int SUM_W = 48;
    localparam int MOTOR_W = 11;

    // configuration register indexes
    localparam logic [2:0] REG_ROLL_PROP  = 3'd0;
    localparam logic [2:0] REG_ROLL_RATE  = 3'd1;
    localparam logic [2:0] REG_PITCH_PROP = 3'd2;
    localparam logic [2:0] REG_PITCH_RATE = 3'd3;
    localparam logic [2:0] REG_YAW_PROP   = 3'd4;
    localparam logic [2:0] REG_YAW_INT    = 3'd5;
    localparam logic [2:0] REG_YAW_RATE   = 3'd6;
    localparam logic [2:0] REG_YAW_LIMIT  = 3'd7;

    typedef struct packed {
        logic signed [15:0] want_roll;
        logic signed [15:0] want_pitch;
        logic signed [15:0] want_yaw;
        logic signed [15:0] meas_roll;
        logic signed [15:0] meas_pitch;
        logic signed [15:0] meas_yaw;
        logic signed [15:0] roll_rate;
        logic signed [15:0] pitch_rate;
        logic signed [15:0] yaw_rate;
        logic        [15:0] throttle;
    } sample_t;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor_front_left;
        logic [MOTOR_W-1:0] motor_front_right;
        logic [MOTOR_W-1:0] motor_rear_right;
        logic [MOTOR_W-1:0] motor_rear_left;
    } motor_cmd_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] value;
    } cfg_write_t;

endpackage

// ----- rtl/qapm_stream_if.sv -----
`timescale 1ns / 1ps

interface qapm_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/quad_attitude_pid_mixer_unit.sv -----
`timescale 1ns / 1ps

// quad-x attitude controller and motor mixer
// channels (valid/ready, transfer when both are high at a rising edge):
//   sample : sink of angle, rate and throttle items (sample_t)
//   motor  : source of four clipped motor commands (motor_cmd_t)
//   cfg    : register writes, index 0..7 selects the gain or the yaw limit; always
//            ready; the user must write only while the block is idle (not enforced)
// pipeline: input register, product stage with the yaw integrator and the
//   result register
// throughput: one item per cycle while motor.ready stays high; the only
//   feedback is the yaw integrator add and clamp, which closes in the product stage
// stall: when motor.ready is low the result register holds; the stages in
//   front keep filling, so up to two more items are taken before
//   sample.ready drops
// reset: all gains, the yaw limit and the integrator clear to zero and all
//   stages come up empty
module quad_attitude_pid_mixer_unit
    import qapm_pkg::*;
#(
    parameter int MOTOR_MIN = 48,
    parameter int MOTOR_MAX = 2047
) (
    input  logic          clk,
    input  logic          rst_n,
    qapm_stream_if.sink   sample,
    qapm_stream_if.source motor,
    qapm_stream_if.sink   cfg
);

    // throttle span, may be negative if the limits are swapped
    localparam logic signed [12:0] THR_SPAN = 13'(MOTOR_MAX - MOTOR_MIN);
    localparam logic signed [SUM_W-1:0] MIN_Q = SUM_W'(MOTOR_MIN) <<< FRAC;
    localparam logic signed [SUM_W-1:0] MAX_Q = SUM_W'(MOTOR_MAX) <<< FRAC;

    // configuration registers
    logic signed [15:0] roll_prop_gain_reg;
    logic signed [15:0] roll_rate_gain_reg;
    logic signed [15:0] pitch_prop_gain_reg;
    logic signed [15:0] pitch_rate_gain_reg;
    logic signed [15:0] yaw_prop_gain_reg;
    logic signed [15:0] yaw_int_gain_reg;
    logic signed [15:0] yaw_rate_gain_reg;
    logic        [30:0] yaw_int_limit_reg;

    cfg_write_t cfg_wr;
    logic       cfg_fire;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.data;
    assign cfg_fire  = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_prop_gain_reg  <= '0;
            roll_rate_gain_reg  <= '0;
            pitch_prop_gain_reg <= '0;
            pitch_rate_gain_reg <= '0;
            yaw_prop_gain_reg   <= '0;
            yaw_int_gain_reg    <= '0;
            yaw_rate_gain_reg   <= '0;
            yaw_int_limit_reg   <= '0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_wr.index)
                REG_ROLL_PROP:  roll_prop_gain_reg  <= cfg_wr.value[15:0];
                REG_ROLL_RATE:  roll_rate_gain_reg  <= cfg_wr.value[15:0];
                REG_PITCH_PROP: pitch_prop_gain_reg <= cfg_wr.value[15:0];
                REG_PITCH_RATE: pitch_rate_gain_reg <= cfg_wr.value[15:0];
                REG_YAW_PROP:   yaw_prop_gain_reg   <= cfg_wr.value[15:0];
                REG_YAW_INT:    yaw_int_gain_reg    <= cfg_wr.value[15:0];
                REG_YAW_RATE:   yaw_rate_gain_reg   <= cfg_wr.value[15:0];
                REG_YAW_LIMIT:  yaw_int_limit_reg   <= cfg_wr.value[30:0];
            endcase
        end
    end

    // stage enables: each stage loads when it is empty or its successor moves
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_load;
    logic s2_load;
    logic s1_load;

    assign out_load     = !out_valid_reg || motor.ready;
    assign s2_load      = !s2_valid_reg || out_load;
    assign s1_load      = !s1_valid_reg || s2_load;
    assign sample.ready = s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage 1: input register
    sample_t s1_item_reg;

    always_ff @(posedge clk)
    begin
        if (s1_load && sample.valid)
        begin
            s1_item_reg <= sample.data;
        end
    end

    // stage 1 -> 2: angle errors and the gain products
    logic signed [16:0] e_roll;
    logic signed [16:0] e_pitch;
    logic signed [16:0] e_yaw;
    logic signed [32:0] p_roll;
    logic signed [31:0] d_roll;
    logic signed [32:0] p_pitch;
    logic signed [31:0] d_pitch;
    logic signed [32:0] p_yaw;
    logic signed [31:0] d_yaw;
    logic signed [32:0] i_prod;
    logic signed [24:0] i_inc;
    logic signed [29:0] thr_prod;

    assign e_roll  = 17'(s1_item_reg.want_roll) - 17'(s1_item_reg.meas_roll);
    assign e_pitch = 17'(s1_item_reg.want_pitch) - 17'(s1_item_reg.meas_pitch);
    assign e_yaw   = 17'(s1_item_reg.want_yaw) - 17'(s1_item_reg.meas_yaw);

    assign p_roll   = roll_prop_gain_reg * e_roll;
    assign d_roll   = roll_rate_gain_reg * s1_item_reg.roll_rate;
    assign p_pitch  = pitch_prop_gain_reg * e_pitch;
    assign d_pitch  = pitch_rate_gain_reg * s1_item_reg.pitch_rate;
    assign p_yaw    = yaw_prop_gain_reg * e_yaw;
    assign d_yaw    = yaw_rate_gain_reg * s1_item_reg.yaw_rate;
    assign i_prod   = yaw_int_gain_reg * e_yaw;
    assign thr_prod = $signed({1'b0, s1_item_reg.throttle}) * THR_SPAN;

    // integrator increment floored to 12 fraction bits
    assign i_inc = i_prod[32:8];

    // yaw integrator: add, then clamp to the symmetric limit
    logic signed [31:0] yaw_accum_reg;
    logic signed [31:0] yaw_accum_next;
    logic signed [33:0] acc_sum;
    logic signed [33:0] lim_pos;
    logic signed [33:0] lim_neg;
    logic               acc_load;

    assign acc_sum  = 34'(yaw_accum_reg) + 34'(i_inc);
    assign lim_pos  = $signed({3'b000, yaw_int_limit_reg});
    assign lim_neg  = -lim_pos;
    assign acc_load = s2_load && s1_valid_reg;

    always_comb
    begin
        priority if (acc_sum > lim_pos)
        begin
            yaw_accum_next = lim_pos[31:0];
        end
        else if (acc_sum < lim_neg)
        begin
            yaw_accum_next = lim_neg[31:0];
        end
        else
        begin
            yaw_accum_next = acc_sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_accum_reg <= '0;
        end
        else if (acc_load)
        begin
            yaw_accum_reg <= yaw_accum_next;
        end
    end

    // stage 2: registered products; the integrator value of this item sits in
    // yaw_accum_reg, which only moves when the next item enters this stage
    logic signed [32:0] s2_p_roll_reg;
    logic signed [31:0] s2_d_roll_reg;
    logic signed [32:0] s2_p_pitch_reg;
    logic signed [31:0] s2_d_pitch_reg;
    logic signed [32:0] s2_p_yaw_reg;
    logic signed [31:0] s2_d_yaw_reg;
    logic signed [29:0] s2_thr_reg;

    always_ff @(posedge clk)
    begin
        if (acc_load)
        begin
            s2_p_roll_reg  <= p_roll;
            s2_d_roll_reg  <= d_roll;
            s2_p_pitch_reg <= p_pitch;
            s2_d_pitch_reg <= d_pitch;
            s2_p_yaw_reg   <= p_yaw;
            s2_d_yaw_reg   <= d_yaw;
            s2_thr_reg     <= thr_prod;
        end
    end

    // stage 2 -> result: control sums, quad-x mixer and clip
    logic signed [SUM_W-1:0] u_roll;
    logic signed [SUM_W-1:0] u_pitch;
    logic signed [SUM_W-1:0] u_yaw;
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] mix [4];
    logic        [MOTOR_W-1:0] clip [4];
    motor_cmd_t              motor_next;

    assign u_roll  = SUM_W'(s2_p_roll_reg) - SUM_W'(s2_d_roll_reg);
    assign u_pitch = SUM_W'(s2_p_pitch_reg) - SUM_W'(s2_d_pitch_reg);
    assign u_yaw   = SUM_W'(s2_p_yaw_reg) + (SUM_W'(yaw_accum_reg) <<< 8)
                   - SUM_W'(s2_d_yaw_reg);
    assign base    = MIN_Q + (SUM_W'(s2_thr_reg) <<< 4);

    // front left, front right, rear right, rear left
    assign mix[0] = base + u_roll + u_pitch - u_yaw;
    assign mix[1] = base - u_roll + u_pitch + u_yaw;
    assign mix[2] = base - u_roll - u_pitch - u_yaw;
    assign mix[3] = base + u_roll - u_pitch + u_yaw;

    // low test first; in range the value is non-negative, so truncation is
    // a plain bit select
    always_comb
    begin
        for (int m = 0; m < 4; m++)
        begin
            priority if (mix[m] < MIN_Q)
            begin
                clip[m] = MOTOR_W'(MOTOR_MIN);
            end
            else if (mix[m] > MAX_Q)
            begin
                clip[m] = MOTOR_W'(MOTOR_MAX);
            end
            else
            begin
                clip[m] = mix[m][FRAC +: MOTOR_W];
            end
        end
    end

    assign motor_next.motor_front_left  = clip[0];
    assign motor_next.motor_front_right = clip[1];
    assign motor_next.motor_rear_right  = clip[2];
    assign motor_next.motor_rear_left   = clip[3];

    // result register
    motor_cmd_t out_item_reg;

    always_ff @(posedge clk)
    begin
        if (out_load && s2_valid_reg)
        begin
            out_item_reg <= motor_next;
        end
    end

    assign motor.valid = out_valid_reg;
    assign motor.data  = out_item_reg;

    // integrator stays inside the limit that was in force at its update
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(acc_load) |->
            (34'(yaw_accum_reg) <= $signed({3'b000, $past(yaw_int_limit_reg)}) &&
             34'(yaw_accum_reg) >= -$signed({3'b000, $past(yaw_int_limit_reg)})))
        else $error("yaw integrator outside its clamp");

    // integrator moves only when an item enters the product stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(acc_load) |-> $stable(yaw_accum_reg))
        else $error("yaw integrator changed without an item");

    // a full, stalled pipeline takes no new sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && out_valid_reg && !motor.ready)
            |-> !sample.ready)
        else $error("sample taken while pipeline is full");

    // front left and rear right motor commands stay inside the thrust range
    assert property (@(posedge clk) disable iff (!rst_n)
        (motor.valid && (MOTOR_MIN <= MOTOR_MAX)) |->
            (int'(motor.data.motor_front_left) >= MOTOR_MIN &&
             int'(motor.data.motor_front_left) <= MOTOR_MAX &&
             int'(motor.data.motor_rear_right) >= MOTOR_MIN &&
             int'(motor.data.motor_rear_right) <= MOTOR_MAX))
        else $error("motor command outside thrust range");

endmodule

// ----- test/quad_attitude_pid_mixer_unit_tb.sv -----
`timescale 1ns / 1ps

module quad_attitude_pid_mixer_unit_tb;
    import qapm_pkg::*;

    localparam int MOTOR_MIN       = 48;
    localparam int MOTOR_MAX       = 2047;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 100;
    // drain time after the last owed result, to cover the pipeline tail
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 10;

    localparam logic [15:0] Q_MAX = 16'h7FFF;
    localparam logic [15:0] Q_MIN = 16'h8000;

    typedef enum logic { ROW_REG, ROW_SAMPLE } row_kind_t;

    // one line of the directed stimulus: a register write or a sample,
    // the latter with an optional hand-typed motor result
    typedef struct {
        row_kind_t  kind;
        cfg_write_t wr;
        sample_t    smp;
        bit         typed;
        motor_cmd_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    qapm_stream_if #(.T(sample_t))    sample_ch ();
    qapm_stream_if #(.T(motor_cmd_t)) motor_ch ();
    qapm_stream_if #(.T(cfg_write_t)) cfg_ch ();

    quad_attitude_pid_mixer_unit #(
        .MOTOR_MIN (MOTOR_MIN),
        .MOTOR_MAX (MOTOR_MAX)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .motor  (motor_ch),
        .cfg    (cfg_ch)
    );

    // shadow copy of the block: gains, yaw clamp and yaw integrator
    logic signed [15:0] gain_shadow [0:6];
    logic [30:0]        limit_shadow;
    longint             yaw_integ;

    // motor commands still owed by the block, oldest first
    motor_cmd_t expected_cmds [$];
    stim_row_t  stim_rows [$];

    // random idling on both sides, switched off for some phases
    bit                 idle_on;
    logic signed [15:0] yaw_bias;

    int items_sent;
    int results_checked;
    int reg_writes;
    int settings_used;
    int mismatches;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // clip a Q20 motor sum to the thrust range, low test first
    function automatic logic [MOTOR_W-1:0] clip_thrust(longint v);
        longint lo = longint'(MOTOR_MIN) <<< FRAC;
        longint hi = longint'(MOTOR_MAX) <<< FRAC;
        if (v < lo)
            return MOTOR_W'(MOTOR_MIN);
        else if (v > hi)
            return MOTOR_W'(MOTOR_MAX);
        else
            return MOTOR_W'(v >>> FRAC);
    endfunction

    // pd on roll and pitch, clamped pid on yaw, quad-x mixer;
    // advances the yaw integrator as the block does on a transfer
    function automatic motor_cmd_t predict_mix(sample_t s);
        longint e_roll  = longint'($signed(s.want_roll)) - longint'($signed(s.meas_roll));
        longint e_pitch = longint'($signed(s.want_pitch)) - longint'($signed(s.meas_pitch));
        longint e_yaw   = longint'($signed(s.want_yaw)) - longint'($signed(s.meas_yaw));
        longint r_roll  = longint'($signed(s.roll_rate));
        longint r_pitch = longint'($signed(s.pitch_rate));
        longint r_yaw   = longint'($signed(s.yaw_rate));
        longint thr     = longint'(s.throttle);
        longint lim     = longint'(limit_shadow);
        longint u_roll;
        longint u_pitch;
        longint u_yaw;
        longint acc;
        longint base;
        motor_cmd_t m;

        u_roll  = longint'(gain_shadow[REG_ROLL_PROP]) * e_roll
                - longint'(gain_shadow[REG_ROLL_RATE]) * r_roll;
        u_pitch = longint'(gain_shadow[REG_PITCH_PROP]) * e_pitch
                - longint'(gain_shadow[REG_PITCH_RATE]) * r_pitch;

        // increment floored to 12 fraction bits, then the symmetric clamp
        acc = yaw_integ + ((longint'(gain_shadow[REG_YAW_INT]) * e_yaw) >>> 8);
        if (acc > lim)
            acc = lim;
        if (acc < -lim)
            acc = -lim;
        yaw_integ = acc;

        u_yaw = longint'(gain_shadow[REG_YAW_PROP]) * e_yaw + acc * 256
              - longint'(gain_shadow[REG_YAW_RATE]) * r_yaw;

        base = (longint'(MOTOR_MIN) <<< FRAC)
             + thr * longint'(MOTOR_MAX - MOTOR_MIN) * 16;

        m.motor_front_left  = clip_thrust(base + u_roll + u_pitch - u_yaw);
        m.motor_front_right = clip_thrust(base - u_roll + u_pitch + u_yaw);
        m.motor_rear_right  = clip_thrust(base - u_roll - u_pitch - u_yaw);
        m.motor_rear_left   = clip_thrust(base + u_roll - u_pitch + u_yaw);
        return m;
    endfunction

    function void note_reg_write(cfg_write_t w);
        case (w.index)
            REG_YAW_LIMIT: limit_shadow = w.value[30:0];
            default:       gain_shadow[w.index] = w.value[15:0];
        endcase
    endfunction

    function void add_reg(logic [2:0] idx, logic [31:0] value);
        stim_row_t row;
        row = '{kind: ROW_REG, wr: cfg_write_t'{idx, value}, smp: '0, typed: 1'b0,
                want: '0};
        stim_rows.push_back(row);
    endfunction

    function void add_smp(sample_t s, bit typed, motor_cmd_t want);
        stim_row_t row;
        row = '{kind: ROW_SAMPLE, wr: '0, smp: s, typed: typed, want: want};
        stim_rows.push_back(row);
    endfunction

    function void build_table();
        // all gains zero after reset: the motors follow the throttle alone
        add_smp(sample_t'{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                          16'h0000}, 1'b1, motor_cmd_t'{11'd48, 11'd48, 11'd48, 11'd48});
        add_smp(sample_t'{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                          16'hFFFF}, 1'b1, motor_cmd_t'{11'd2046, 11'd2046, 11'd2046,
                          11'd2046});
        add_smp(sample_t'{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                          16'h0000}, 1'b1, motor_cmd_t'{11'd48, 11'd48, 11'd48, 11'd48});
        add_smp(sample_t'{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                          16'h8000}, 1'b1, motor_cmd_t'{11'd1047, 11'd1047, 11'd1047,
                          11'd1047});

        // full roll gain on the widest roll error: left side high, right side low
        add_reg(REG_ROLL_PROP, 32'h0000_7FFF);
        add_smp(sample_t'{Q_MAX, 16'h0, 16'h0, Q_MIN, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                          16'h8000}, 1'b1, motor_cmd_t'{11'd2047, 11'd48, 11'd48, 11'd2047});

        // roll and pitch each add 999.5: front left lands exactly on the top,
        // front right exactly on the bottom
        add_reg(REG_ROLL_PROP, 32'hA5A5_7CF0);
        add_reg(REG_PITCH_PROP, 32'h0000_7CF0);
        add_smp(sample_t'{Q_MAX, Q_MAX, 16'h0, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0,
                          16'h0, 16'h0000}, 1'b1, motor_cmd_t'{11'd2047, 11'd48, 11'd48,
                          11'd48});
        // one more lsb of roll error: a fraction above the top, a fraction below
        // the bottom, both still clip
        add_smp(sample_t'{Q_MAX, Q_MAX, 16'h0, 16'hFFFE, 16'hFFFF, 16'h0, 16'h0, 16'h0,
                          16'h0, 16'h0000}, 1'b1, motor_cmd_t'{11'd2047, 11'd48, 11'd48,
                          11'd48});

        // rate damping with opposite sign extremes
        add_reg(REG_ROLL_PROP, 32'h0000_0200);
        add_reg(REG_PITCH_PROP, 32'hFFFF_FE00);
        add_reg(REG_ROLL_RATE, 32'h0000_8000);
        add_reg(REG_PITCH_RATE, 32'h5A5A_7FFF);
        add_smp(sample_t'{16'h0100, 16'hFF00, 16'h0, 16'h0080, 16'h0040, 16'h0, Q_MAX,
                          Q_MIN, 16'h0, 16'h8000}, 1'b0, '0);
        add_smp(sample_t'{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, Q_MIN, Q_MAX, 16'h0,
                          16'h4000}, 1'b0, '0);
        add_smp(sample_t'{16'hF000, 16'h1000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0123,
                          16'hFEDC, 16'h0, 16'hC000}, 1'b0, '0);

        // yaw pid: drive the integrator into the upper clamp, then the lower one
        add_reg(REG_YAW_PROP, 32'h0000_0100);
        add_reg(REG_YAW_INT, 32'h0000_4000);
        add_reg(REG_YAW_RATE, 32'h0000_8000);
        add_reg(REG_YAW_LIMIT, 32'h0010_0000);
        repeat (3)
            add_smp(sample_t'{16'h0, 16'h0, Q_MAX, 16'h0, 16'h0, Q_MIN, 16'h0, 16'h0,
                              16'h0100, 16'h8000}, 1'b0, '0);
        repeat (3)
            add_smp(sample_t'{16'h0, 16'h0, Q_MIN, 16'h0, 16'h0, Q_MAX, 16'h0, 16'h0,
                              16'hFF00, 16'h8000}, 1'b0, '0);

        // limit lowered under a full integrator: clamp takes hold on the next item
        add_reg(REG_YAW_LIMIT, 32'h0000_0100);
        add_smp(sample_t'{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                          16'h8000}, 1'b0, '0);
        // top bit of the write is dropped, so this is a zero limit
        add_reg(REG_YAW_LIMIT, 32'h8000_0000);
        add_smp(sample_t'{16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                          16'h0, 16'h8000}, 1'b0, '0);
    endfunction

    // q3.12 value, either anywhere in range or within one radian or so
    function automatic logic [15:0] draw_q312(bit wide);
        return wide ? 16'($urandom) : 16'($urandom_range(0, 8191) - 4096);
    endfunction

    // mostly modest attitudes around a yaw offset that holds for a stretch,
    // so the integrator winds up; one item in eight is full range noise
    function automatic sample_t rand_sample(int k);
        sample_t s;
        bit wide;
        wide = ($urandom_range(0, 7) == 0);
        if (k % 16 == 0)
            yaw_bias = 16'($urandom_range(0, 8191) - 4096);
        s.want_roll  = draw_q312(wide);
        s.want_pitch = draw_q312(wide);
        s.want_yaw   = wide ? 16'($urandom) : 16'(yaw_bias + $urandom_range(0, 255) - 128);
        s.meas_roll  = draw_q312(wide);
        s.meas_pitch = draw_q312(wide);
        s.meas_yaw   = draw_q312(wide);
        s.roll_rate  = draw_q312(wide);
        s.pitch_rate = draw_q312(wide);
        s.yaw_rate   = draw_q312(wide);
        s.throttle   = wide ? 16'($urandom) : 16'($urandom_range(16384, 49152));
        return s;
    endfunction

    // register write only with nothing in flight
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        sample_ch.valid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= cfg_write_t'{idx, value};
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        note_reg_write(cfg_write_t'{idx, value});
        reg_writes++;
    endtask

    // valid stays high when the next sample follows with no gap
    task automatic send_sample(sample_t s, bit typed, motor_cmd_t typed_cmd);
        int gap;
        motor_cmd_t pred;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        cfg_ch.valid <= 1'b0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= s;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        // the predictor always runs so the integrator copy keeps in step
        pred = predict_mix(s);
        expected_cmds.push_back(typed ? typed_cmd : pred);
        items_sent++;
    endtask

    // every register once per phase, starting at a random index; the first
    // two phases pin all gains to the extremes and the limit to max and zero
    task automatic program_phase(int p);
        int first;
        logic [2:0] idx;
        logic [15:0] g;
        logic [30:0] lim;
        first = $urandom_range(0, 7);
        for (int j = 0; j < 8; j++)
        begin
            idx = 3'((first + j) % 8);
            if (idx == REG_YAW_LIMIT)
            begin
                if (p == 0)
                    lim = '1;
                else if (p == 1)
                    lim = '0;
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       lim = '0;
                        1:       lim = 31'($urandom_range(0, 1 << 22));
                        2:       lim = 31'($urandom);
                        default: lim = '1;
                    endcase
                end
                write_reg(idx, {1'($urandom), lim});
            end
            else
            begin
                if (p == 0)
                    g = Q_MAX;
                else if (p == 1)
                    g = Q_MIN;
                else if ($urandom_range(0, 1) == 1)
                    g = 16'($urandom);
                else
                    g = 16'($urandom_range(0, 8191) - 4096);
                write_reg(idx, {16'($urandom), g});
            end
        end
        settings_used++;
    endtask

    // compare a motor transfer against the oldest owed command
    function void check_cmd(motor_cmd_t got);
        motor_cmd_t want;
        bit bad;
        if (expected_cmds.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: motor result with none owed: fl %0d fr %0d rr %0d rl %0d",
                         $realtime, got.motor_front_left, got.motor_front_right,
                         got.motor_rear_right, got.motor_rear_left);
            return;
        end
        want = expected_cmds.pop_front();
        results_checked++;
        bad = (got.motor_front_left  !== want.motor_front_left)
           || (got.motor_front_right !== want.motor_front_right)
           || (got.motor_rear_right  !== want.motor_rear_right)
           || (got.motor_rear_left   !== want.motor_rear_left);
        if (bad)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: result %0d expected fl %0d fr %0d rr %0d rl %0d, ",
                         $realtime, results_checked, want.motor_front_left,
                         want.motor_front_right, want.motor_rear_right,
                         want.motor_rear_left,
                         "got fl %0d fr %0d rr %0d rl %0d", got.motor_front_left,
                         got.motor_front_right, got.motor_rear_right,
                         got.motor_rear_left);
        end
    endfunction

    // motor side: random back-pressure, one check per transfer
    initial
    begin : motor_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0)
            begin
                motor_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            motor_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!motor_ch.valid);
            check_cmd(motor_ch.data);
        end
    end

    // sample and register side: directed table, then random phases
    initial
    begin : stimulus
        stim_row_t row;
        rst_n           = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        motor_ch.ready  = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        foreach (gain_shadow[i])
            gain_shadow[i] = '0;
        limit_shadow    = '0;
        yaw_integ       = 0;
        yaw_bias        = '0;
        idle_on         = 1'b1;
        items_sent      = 0;
        results_checked = 0;
        reg_writes      = 0;
        settings_used   = 1;
        mismatches      = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        build_table();
        foreach (stim_rows[r])
        begin
            row = stim_rows[r];
            if (row.kind == ROW_REG)
                write_reg(row.wr.index, row.wr.value);
            else
                send_sample(row.smp, row.typed, row.want);
        end

        // every fourth phase runs with no gaps and no stalls
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            idle_on = (p % 4 != 3);
            program_phase(p);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_sample(rand_sample(k), 1'b0, '0);
        end

        sample_ch.valid <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
        // catch any stray result after the last owed one
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d samples under %0d register settings (%0d register writes)",
                 items_sent, settings_used, reg_writes);
        $display("checked %0d motor results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("quad_attitude_pid_mixer_unit_tb OK");
        else
            $display("quad_attitude_pid_mixer_unit_tb NOT OK");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin : watchdog
        #5_000_000;
        $display("timeout with %0d motor results outstanding", expected_cmds.size());
        $display("quad_attitude_pid_mixer_unit_tb NOT OK");
        $finish;
    end

endmodule
